// File: rtl/core/accumulator_bytecode_executor_macros.svh
// ----------------------------------------------------------------------------
// accumulator bytecode executor assertion macros
// concurrent property shorthands used by the port-level checker
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_BYTECODE_EXECUTOR_MACROS_SVH
`define ACCUMULATOR_BYTECODE_EXECUTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define ABE_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ABE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/core/abe_pkg.sv
// ----------------------------------------------------------------------------
// abe_pkg
// opcodes, end causes, unit op codes and inter-module structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abe_pkg;

    // bytecode opcodes
    localparam logic [7:0] OP_LDI  = 8'h01;
    localparam logic [7:0] OP_ADD  = 8'h02;
    localparam logic [7:0] OP_SUB  = 8'h03;
    localparam logic [7:0] OP_AND  = 8'h04;
    localparam logic [7:0] OP_OR   = 8'h05;
    localparam logic [7:0] OP_XOR  = 8'h06;
    localparam logic [7:0] OP_STA  = 8'h07;
    localparam logic [7:0] OP_LDF  = 8'h08;
    localparam logic [7:0] OP_NEG  = 8'h09;
    localparam logic [7:0] OP_NOT  = 8'h0A;
    localparam logic [7:0] OP_CLRF = 8'h0B;
    localparam logic [7:0] OP_INC  = 8'h0C;
    localparam logic [7:0] OP_DEC  = 8'h0D;
    localparam logic [7:0] OP_RET  = 8'h0E;
    localparam logic [7:0] OP_MUL  = 8'h0F;
    localparam logic [7:0] OP_DIV  = 8'h10;
    localparam logic [7:0] OP_MOD  = 8'h11;
    localparam logic [7:0] OP_SHL  = 8'h12;
    localparam logic [7:0] OP_SHR  = 8'h13;
    localparam logic [7:0] OP_GT   = 8'h14;
    localparam logic [7:0] OP_LT   = 8'h15;
    localparam logic [7:0] OP_EQ   = 8'h16;

    // end causes
    localparam logic [1:0] CAUSE_RET     = 2'd0;
    localparam logic [1:0] CAUSE_UNKNOWN = 2'd1;
    localparam logic [1:0] CAUSE_LAST    = 2'd2;

    localparam logic [7:0] ALL_ONES = 8'hFF;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD,
        ALU_SHL,
        ALU_SHR,
        ALU_GT,
        ALU_LT,
        ALU_EQ
    } alu_op_t;

    typedef struct packed {
        logic       start;
        alu_op_t    op;
        logic [7:0] a;
        logic [7:0] b;
    } alu_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] y;
    } alu_rsp_t;

    typedef struct packed {
        logic       clear;
        logic       rd_en;
        logic       wr_en;
        logic [7:0] addr;
        logic [7:0] wr_data;
    } file_req_t;

    // unit operation for opcodes that take acc and a file byte
    function automatic alu_op_t alu_op_of(input logic [7:0] func);
        alu_op_t op;
        case (func)
            OP_SUB:  op = ALU_SUB;
            OP_AND:  op = ALU_AND;
            OP_OR:   op = ALU_OR;
            OP_XOR:  op = ALU_XOR;
            OP_MUL:  op = ALU_MUL;
            OP_DIV:  op = ALU_DIV;
            OP_MOD:  op = ALU_MOD;
            OP_SHL:  op = ALU_SHL;
            OP_SHR:  op = ALU_SHR;
            OP_GT:   op = ALU_GT;
            OP_LT:   op = ALU_LT;
            OP_EQ:   op = ALU_EQ;
            default: op = ALU_ADD;
        endcase
        return op;
    endfunction

endpackage

// File: rtl/core/abe_alu.sv
// ----------------------------------------------------------------------------
// abe_alu
// shared 9-bit adder unit: one step for simple ops, eight for mul/div/mod
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abe_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  abe_pkg::alu_req_t req,
    output abe_pkg::alu_rsp_t rsp
);

    abe_pkg::alu_op_t op_reg;
    logic [7:0]       a_reg;
    logic [7:0]       b_reg;
    logic [7:0]       p_reg;    // product or partial remainder
    logic [7:0]       q_reg;    // dividend shifting into quotient
    logic [7:0]       y_reg;
    logic [2:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [8:0] add_x;
    logic [8:0] add_y;
    logic       add_sub;
    logic [9:0] sum;
    logic       no_borrow;
    logic       multi;
    logic       last_step;
    logic [7:0] rem_new;
    logic [7:0] quo_new;
    logic [7:0] step_y;

    // operand steering into the single adder
    always_comb
    begin
        add_x   = {1'b0, a_reg};
        add_y   = {1'b0, b_reg};
        add_sub = 1'b0;
        case (op_reg)
            abe_pkg::ALU_SUB, abe_pkg::ALU_LT, abe_pkg::ALU_EQ:
            begin
                add_sub = 1'b1;
            end
            abe_pkg::ALU_GT:
            begin
                add_x   = {1'b0, b_reg};
                add_y   = {1'b0, a_reg};
                add_sub = 1'b1;
            end
            abe_pkg::ALU_MUL:
            begin
                add_x = {1'b0, p_reg[6:0], 1'b0};
                add_y = b_reg[7] ? {1'b0, a_reg} : 9'd0;
            end
            abe_pkg::ALU_DIV, abe_pkg::ALU_MOD:
            begin
                add_x   = {p_reg, q_reg[7]};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    assign sum       = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + {9'd0, add_sub};
    assign no_borrow = sum[9];
    assign rem_new   = no_borrow ? sum[7:0] : {p_reg[6:0], q_reg[7]};
    assign quo_new   = {q_reg[6:0], no_borrow};
    assign multi     = (op_reg == abe_pkg::ALU_MUL) || (op_reg == abe_pkg::ALU_DIV) ||
                       (op_reg == abe_pkg::ALU_MOD);
    assign last_step = !multi || (cnt_reg == 3'd7);

    always_comb
    begin
        case (op_reg)
            abe_pkg::ALU_AND: step_y = a_reg & b_reg;
            abe_pkg::ALU_OR:  step_y = a_reg | b_reg;
            abe_pkg::ALU_XOR: step_y = a_reg ^ b_reg;
            abe_pkg::ALU_SHL: step_y = a_reg << b_reg[2:0];
            abe_pkg::ALU_SHR: step_y = a_reg >> b_reg[2:0];
            abe_pkg::ALU_GT:  step_y = {7'd0, !no_borrow};
            abe_pkg::ALU_LT:  step_y = {7'd0, !no_borrow};
            abe_pkg::ALU_EQ:  step_y = {7'd0, (sum[7:0] == 8'd0)};
            abe_pkg::ALU_DIV: step_y = quo_new;
            abe_pkg::ALU_MOD: step_y = rem_new;
            default:          step_y = sum[7:0];
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg <= req.op;
            a_reg  <= req.a;
            b_reg  <= req.b;
            p_reg  <= 8'd0;
            q_reg  <= req.a;
        end
        else if (busy_reg)
        begin
            if (op_reg == abe_pkg::ALU_MUL)
            begin
                p_reg <= sum[7:0];
                b_reg <= {b_reg[6:0], 1'b0};
            end
            else if ((op_reg == abe_pkg::ALU_DIV) || (op_reg == abe_pkg::ALU_MOD))
            begin
                p_reg <= rem_new;
                q_reg <= quo_new;
            end
            if (last_step)
            begin
                y_reg <= step_y;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.y    = y_reg;

endmodule

// File: rtl/core/abe_file.sv
// ----------------------------------------------------------------------------
// abe_file
// file register memory with registered read and per-entry valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abe_file #(
    parameter int FILE_DEPTH = 224
) (
    input  logic               clk,
    input  logic               rst_n,
    input  abe_pkg::file_req_t req,
    output logic [7:0]         rd_data
);

    localparam int FILE_AW = (FILE_DEPTH > 1) ? $clog2(FILE_DEPTH) : 1;

    logic [7:0]            mem [FILE_DEPTH];
    logic [FILE_DEPTH-1:0] vld_reg;
    logic [7:0]            data_reg;
    logic                  hit_reg;
    logic [FILE_AW-1:0]    idx;

    assign idx = req.addr[FILE_AW-1:0];

    // entries not written since start read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                vld_reg[idx] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= vld_reg[idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[idx] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_reg <= mem[idx];
        end
    end

    assign rd_data = hit_reg ? data_reg : 8'd0;

endmodule

// File: rtl/core/accumulator_bytecode_executor.sv
// ----------------------------------------------------------------------------
// accumulator_bytecode_executor
// 8-bit accumulator bytecode engine, one instruction per input transaction
// ----------------------------------------------------------------------------
// Each input transaction is one instruction. tdata carries the opcode, the
// operand byte (immediate for load, file index otherwise) and the start
// byte; tuser[0] starts a program (file cleared through valid bits,
// accumulator loaded from the start byte) and tlast marks the final
// instruction. A program that ends gives one output transaction: the
// accumulator as a signed byte with the end cause in tuser (return, unknown
// opcode with a zero value, or end of code). Transactions between programs
// are dropped. The sequencer walks fetch, decode, optional unit run and
// finish, one instruction at a time, around one shared adder unit and one
// registered-read file port: loads, stores, clears and return skip the unit
// run, which takes one step for add, sub, logic, shifts, compares, inc, dec,
// negate and not and eight bit-serial steps for multiply, divide and modulo.
// A result waiting in the output register does not hold up the next
// instruction until that one has its own result to deliver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accumulator_bytecode_executor #(
    parameter int MEM_BYTES = 256,
    parameter int FILE_BASE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // instruction transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // func[7:0], operand[15:8], start_value[23:16]
    input  logic [0:0]  s_tuser,   // is_first[0]
    input  logic        s_tlast,   // is_last
    // result transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // result_value[7:0]
    output logic [1:0]  m_tuser    // end_cause[1:0]
);

    localparam int FILE_DEPTH = MEM_BYTES - FILE_BASE;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t     state_reg,    state_next;
    logic [7:0] func_reg,     func_next;
    logic [7:0] operand_reg,  operand_next;
    logic       last_reg,     last_next;
    logic [7:0] acc_reg,      acc_next;
    logic       halted_reg,   halted_next;
    logic       tgt_file_reg, tgt_file_next;   // unit result goes to the file
    logic       emit_reg,     emit_next;
    logic [1:0] cause_reg,    cause_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_data_reg,   m_data_next;
    logic [1:0] m_cause_reg,  m_cause_next;

    logic               ok;
    logic [7:0]         file_rd_data;
    abe_pkg::file_req_t file_req;
    abe_pkg::alu_req_t  alu_req;
    abe_pkg::alu_rsp_t  alu_rsp;

    // index in range of the register file
    assign ok = ({1'b0, operand_reg} < 9'(FILE_DEPTH));

    abe_file #(
        .FILE_DEPTH (FILE_DEPTH)
    ) u_file (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (file_req),
        .rd_data (file_rd_data)
    );

    abe_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        operand_next  = operand_reg;
        last_next     = last_reg;
        acc_next      = acc_reg;
        halted_next   = halted_reg;
        tgt_file_next = tgt_file_reg;
        emit_next     = emit_reg;
        cause_next    = cause_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        m_cause_next  = m_cause_reg;

        file_req.clear   = 1'b0;
        file_req.rd_en   = 1'b0;
        file_req.wr_en   = 1'b0;
        file_req.addr    = operand_reg;
        file_req.wr_data = 8'd0;

        alu_req.start = 1'b0;
        alu_req.op    = abe_pkg::ALU_ADD;
        alu_req.a     = acc_reg;
        alu_req.b     = file_rd_data;

        // output register drains independently of the sequencer
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next    = s_tdata[7:0];
                    operand_next = s_tdata[15:8];
                    last_next    = s_tlast;
                    if (s_tuser[0])
                    begin
                        // program start: clear file, load accumulator
                        file_req.clear = 1'b1;
                        acc_next       = s_tdata[23:16];
                        halted_next    = 1'b0;
                        state_next     = S_FETCH;
                    end
                    else if (!halted_reg)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end

            S_FETCH:
            begin
                file_req.rd_en = ok;
                state_next     = S_DECODE;
            end

            S_DECODE:
            begin
                emit_next   = last_reg;
                cause_next  = abe_pkg::CAUSE_LAST;
                halted_next = last_reg;
                state_next  = S_FINISH;
                unique case (func_reg) inside
                    abe_pkg::OP_LDI:
                    begin
                        acc_next = operand_reg;
                    end
                    abe_pkg::OP_ADD, abe_pkg::OP_SUB, abe_pkg::OP_AND, abe_pkg::OP_OR,
                    abe_pkg::OP_XOR, abe_pkg::OP_MUL, abe_pkg::OP_SHL, abe_pkg::OP_SHR,
                    abe_pkg::OP_GT, abe_pkg::OP_LT, abe_pkg::OP_EQ:
                    begin
                        if (ok)
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = abe_pkg::alu_op_of(func_reg);
                            tgt_file_next = 1'b0;
                            state_next    = S_WAIT;
                        end
                    end
                    abe_pkg::OP_DIV, abe_pkg::OP_MOD:
                    begin
                        // divide by zero keeps the accumulator
                        if (ok && (file_rd_data != 8'd0))
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = abe_pkg::alu_op_of(func_reg);
                            tgt_file_next = 1'b0;
                            state_next    = S_WAIT;
                        end
                    end
                    abe_pkg::OP_STA:
                    begin
                        file_req.wr_en   = ok;
                        file_req.wr_data = acc_reg;
                    end
                    abe_pkg::OP_LDF:
                    begin
                        if (ok)
                        begin
                            acc_next = file_rd_data;
                        end
                    end
                    abe_pkg::OP_NEG:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = abe_pkg::ALU_SUB;
                        alu_req.a     = 8'd0;
                        alu_req.b     = acc_reg;
                        tgt_file_next = 1'b0;
                        state_next    = S_WAIT;
                    end
                    abe_pkg::OP_NOT:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = abe_pkg::ALU_XOR;
                        alu_req.b     = abe_pkg::ALL_ONES;
                        tgt_file_next = 1'b0;
                        state_next    = S_WAIT;
                    end
                    abe_pkg::OP_CLRF:
                    begin
                        file_req.wr_en = ok;
                    end
                    abe_pkg::OP_INC, abe_pkg::OP_DEC:
                    begin
                        if (ok)
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = (func_reg == abe_pkg::OP_INC) ?
                                            abe_pkg::ALU_ADD : abe_pkg::ALU_SUB;
                            alu_req.a     = file_rd_data;
                            alu_req.b     = 8'd1;
                            tgt_file_next = 1'b1;
                            state_next    = S_WAIT;
                        end
                    end
                    abe_pkg::OP_RET:
                    begin
                        emit_next   = 1'b1;
                        cause_next  = abe_pkg::CAUSE_RET;
                        halted_next = 1'b1;
                    end
                    default:
                    begin
                        // unknown opcode stops the program with a zero result
                        emit_next   = 1'b1;
                        cause_next  = abe_pkg::CAUSE_UNKNOWN;
                        halted_next = 1'b1;
                    end
                endcase
            end

            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (tgt_file_reg)
                    begin
                        file_req.wr_en   = 1'b1;
                        file_req.wr_data = alu_rsp.y;
                    end
                    else
                    begin
                        acc_next = alu_rsp.y;
                    end
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!emit_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = (cause_reg == abe_pkg::CAUSE_UNKNOWN) ? 8'd0 : acc_reg;
                    m_cause_next  = cause_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            func_reg     <= 8'd0;
            operand_reg  <= 8'd0;
            last_reg     <= 1'b0;
            acc_reg      <= 8'd0;
            halted_reg   <= 1'b1;
            tgt_file_reg <= 1'b0;
            emit_reg     <= 1'b0;
            cause_reg    <= abe_pkg::CAUSE_RET;
            m_tvalid_reg <= 1'b0;
            m_data_reg   <= 8'd0;
            m_cause_reg  <= abe_pkg::CAUSE_RET;
        end
        else
        begin
            state_reg    <= state_next;
            func_reg     <= func_next;
            operand_reg  <= operand_next;
            last_reg     <= last_next;
            acc_reg      <= acc_next;
            halted_reg   <= halted_next;
            tgt_file_reg <= tgt_file_next;
            emit_reg     <= emit_next;
            cause_reg    <= cause_next;
            m_tvalid_reg <= m_tvalid_next;
            m_data_reg   <= m_data_next;
            m_cause_reg  <= m_cause_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_cause_reg;

endmodule

// File: rtl/core/abe_checker.sv
// ----------------------------------------------------------------------------
// abe_checker
// port-level properties of the bytecode executor, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "accumulator_bytecode_executor_macros.svh"

module abe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    logic start_taken;
    logic cause_known;
    logic unk_out;
    logic val_zero;

    assign start_taken = s_tvalid && s_tready && s_tuser[0];
    assign cause_known = (m_tuser == abe_pkg::CAUSE_RET) || (m_tuser == abe_pkg::CAUSE_UNKNOWN) ||
                         (m_tuser == abe_pkg::CAUSE_LAST);
    assign unk_out     = m_tvalid && (m_tuser == abe_pkg::CAUSE_UNKNOWN);
    assign val_zero    = (m_tdata == 8'd0);

    // a stalled result stays offered
    `ABE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")

    // a program start always runs its instruction
    `ABE_ASSERT_NEXT(a_start_busy, clk, rst_n, start_taken, !s_tready, "start not executed")

    // only the three end causes appear
    `ABE_ASSERT_IMPL(a_cause_code, clk, rst_n, m_tvalid, cause_known, "bad end cause")

    // unknown opcode reports a zero value
    `ABE_ASSERT_IMPL(a_unknown_zero, clk, rst_n, unk_out, val_zero, "unknown opcode value not zero")

endmodule

bind accumulator_bytecode_executor abe_checker u_abe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/accumulator_bytecode_executor_checker.sv
// ----------------------------------------------------------------------------
// accumulator_bytecode_executor_checker
// predicts each program's result from the instruction channel and checks it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accumulator_bytecode_executor_checker #(
    parameter int MEM_BYTES = 256,
    parameter int FILE_BASE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // func[7:0], operand[15:8], start_value[23:16]
    input  logic [0:0]  s_tuser,   // is_first[0]
    input  logic        s_tlast,   // is_last
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // result_value[7:0]
    input  logic [1:0]  m_tuser,   // end_cause[1:0]
    output int          errors,
    output int          outstanding,
    output int          checked
);

    localparam int FILE_DEPTH  = MEM_BYTES - FILE_BASE;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic signed [7:0] value;
        logic [1:0]        cause;
    } prog_result_t;

    logic [7:0]   acc;
    logic [7:0]   file_mem [FILE_DEPTH];
    logic         halted;
    prog_result_t result_q [$];

    initial
    begin
        errors      = 0;
        outstanding = 0;
        checked     = 0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // one instruction through the predicted machine
    task automatic execute(input logic [7:0] func, input logic [7:0] idx,
                           input logic first, input logic [7:0] start,
                           input logic last);
        logic         in_range;
        logic [7:0]   fbyte;
        logic [7:0]   acc_next;
        logic         stops;
        prog_result_t res;
        in_range = idx < FILE_DEPTH;
        if (first)
        begin
            foreach (file_mem[i])
                file_mem[i] = '0;
            acc    = start;
            halted = 1'b0;
        end
        if (halted)
            return;
        fbyte    = in_range ? file_mem[idx] : '0;
        acc_next = acc;
        stops    = 1'b0;
        res      = '0;
        case (func)
            abe_pkg::OP_LDI:  acc_next = idx;
            abe_pkg::OP_ADD:  if (in_range) acc_next = acc + fbyte;
            abe_pkg::OP_SUB:  if (in_range) acc_next = acc - fbyte;
            abe_pkg::OP_AND:  if (in_range) acc_next = acc & fbyte;
            abe_pkg::OP_OR:   if (in_range) acc_next = acc | fbyte;
            abe_pkg::OP_XOR:  if (in_range) acc_next = acc ^ fbyte;
            abe_pkg::OP_STA:  if (in_range) file_mem[idx] = acc;
            abe_pkg::OP_LDF:  if (in_range) acc_next = fbyte;
            abe_pkg::OP_NEG:  acc_next = -acc;
            abe_pkg::OP_NOT:  acc_next = ~acc;
            abe_pkg::OP_CLRF: if (in_range) file_mem[idx] = '0;
            abe_pkg::OP_INC:  if (in_range) file_mem[idx] = fbyte + 8'd1;
            abe_pkg::OP_DEC:  if (in_range) file_mem[idx] = fbyte - 8'd1;
            abe_pkg::OP_RET:
            begin
                stops = 1'b1;
                res   = '{value: acc, cause: abe_pkg::CAUSE_RET};
            end
            abe_pkg::OP_MUL:  if (in_range) acc_next = acc * fbyte;
            // zero divisor keeps the accumulator
            abe_pkg::OP_DIV:  if (in_range && fbyte != 0) acc_next = acc / fbyte;
            abe_pkg::OP_MOD:  if (in_range && fbyte != 0) acc_next = acc % fbyte;
            abe_pkg::OP_SHL:  if (in_range) acc_next = acc << fbyte[2:0];
            abe_pkg::OP_SHR:  if (in_range) acc_next = acc >> fbyte[2:0];
            abe_pkg::OP_GT:   if (in_range) acc_next = {7'd0, acc > fbyte};
            abe_pkg::OP_LT:   if (in_range) acc_next = {7'd0, acc < fbyte};
            abe_pkg::OP_EQ:   if (in_range) acc_next = {7'd0, acc == fbyte};
            default:
            begin
                stops = 1'b1;
                res   = '{value: '0, cause: abe_pkg::CAUSE_UNKNOWN};
            end
        endcase
        if (!stops)
        begin
            acc = acc_next;
            if (last)
            begin
                stops = 1'b1;
                res   = '{value: acc, cause: abe_pkg::CAUSE_LAST};
            end
        end
        if (stops)
        begin
            halted = 1'b1;
            result_q.push_back(res);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc    = '0;
            halted = 1'b1;
            foreach (file_mem[i])
                file_mem[i] = '0;
            result_q.delete();
            outstanding = 0;
        end
        else
        begin
            // results first: an instruction taken at this edge cannot answer yet
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                    report_mismatch($sformatf("unexpected result value %0d cause %0d",
                                              $signed(m_tdata), m_tuser));
                else
                begin
                    prog_result_t want;
                    want = result_q.pop_front();
                    checked++;
                    if (m_tdata !== want.value)
                        report_mismatch($sformatf("result %0d value %0d, expected %0d",
                                                  checked, $signed(m_tdata), want.value));
                    if (m_tuser !== want.cause)
                        report_mismatch($sformatf("result %0d cause %0d, expected %0d",
                                                  checked, m_tuser, want.cause));
                end
            end
            if (s_tvalid && s_tready)
                execute(s_tdata[7:0], s_tdata[15:8], s_tuser[0], s_tdata[23:16], s_tlast);
            outstanding = result_q.size();
        end
    end

endmodule

// File: tb/sv/tb_accumulator_bytecode_executor.sv
// ----------------------------------------------------------------------------
// tb_accumulator_bytecode_executor
// stimulus and verdict for the accumulator bytecode executor
// ----------------------------------------------------------------------------
// A directed program walks every opcode, file index extremes, zero divisors,
// return and unknown opcode on the last instruction and filler while halted.
// Random programs follow: mostly well-formed instruction runs over a small
// pool of file registers, with some unterminated programs, unknown opcodes
// and filler between programs. Both channels idle at random; the checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_accumulator_bytecode_executor;

    localparam int         MEM_BYTES    = 256;
    localparam int         FILE_BASE    = 32;
    localparam logic [7:0] FILE_LAST    = 8'(MEM_BYTES - FILE_BASE - 1);
    localparam logic [7:0] BAD_OP_ZERO  = 8'h00;
    localparam int         TARGET_ITEMS = 2000;
    localparam int         DRAIN_LIMIT  = 5000;
    localparam int         TAIL_CYCLES  = 40;
    localparam int         CYCLE_LIMIT  = 500000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // func[7:0], operand[15:8], start_value[23:16]
    logic [0:0]  s_tuser;   // is_first[0]
    logic        s_tlast;   // is_last
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // result_value[7:0]
    logic [1:0]  m_tuser;   // end_cause[1:0]

    int errors;
    int outstanding;
    int checked;
    int sent_items;
    int filler_items;
    int programs;
    int cycle_count;
    bit no_gaps;   // burst phase: neither side idles

    accumulator_bytecode_executor #(
        .MEM_BYTES (MEM_BYTES),
        .FILE_BASE (FILE_BASE)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    accumulator_bytecode_executor_checker #(
        .MEM_BYTES (MEM_BYTES),
        .FILE_BASE (FILE_BASE)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog against a hung handshake or a lost result
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, outstanding);
            $display("tb_accumulator_bytecode_executor: done, errors");
            $finish;
        end
    end

    // one instruction transaction: optional idle gap, then hold until taken
    task automatic issue(input logic [7:0] func, input logic [7:0] operand,
                         input logic first, input logic [7:0] start, input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {start, operand, func};
        s_tuser  <= first;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        @(negedge clk);
        sent_items++;
    endtask

    // mostly a handful of shared registers so stores feed later reads
    function automatic logic [7:0] pick_index();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return 8'($urandom_range(0, 7));
        if (r < 17)
            return FILE_LAST;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_opcode();
        if ($urandom_range(0, 39) == 0)
            return ($urandom_range(0, 3) == 0) ? BAD_OP_ZERO
                                               : 8'($urandom_range(abe_pkg::OP_EQ + 1,
                                                                   abe_pkg::ALL_ONES));
        return 8'($urandom_range(abe_pkg::OP_EQ, abe_pkg::OP_LDI));
    endfunction

    function automatic bit ends_program(input logic [7:0] func);
        return func == abe_pkg::OP_RET || func < abe_pkg::OP_LDI || func > abe_pkg::OP_EQ;
    endfunction

    // random program: start item, body, last item; a few are left unterminated
    task automatic run_program();
        int         len;
        int         i;
        bit         broken;
        logic [7:0] func;
        logic [7:0] operand;
        len     = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        broken  = ($urandom_range(0, 19) == 0);
        no_gaps = ($urandom_range(0, 5) == 0);
        programs++;
        for (i = 0; i < len; i++)
        begin
            func    = pick_opcode();
            operand = (func == abe_pkg::OP_LDI) ? 8'($urandom) : pick_index();
            issue(func, operand, i == 0, 8'($urandom), (i == len - 1) && !broken);
            if (ends_program(func))
                break;
        end
        // filler between programs: dropped by a halted block
        if (!broken && $urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                issue(8'($urandom), 8'($urandom), 1'b0, 8'($urandom), 1'($urandom));
                filler_items++;
            end
        end
    endtask

    // result side: random stall before each result transaction
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            @(negedge clk);
        end
    end

    initial
    begin
        int n;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        s_tlast      = 1'b0;
        no_gaps      = 1'b0;
        sent_items   = 0;
        filler_items = 0;
        programs     = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed program: every opcode but return, index extremes, zero divisors
        programs++;
        issue(abe_pkg::OP_NEG,  8'd0,             1'b1, 8'hFF, 1'b0);
        issue(abe_pkg::OP_STA,  FILE_LAST,        1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_LDI,  8'hFF,            1'b0, 8'hFF, 1'b0);
        issue(abe_pkg::OP_ADD,  FILE_LAST,        1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_DIV,  8'd0,             1'b0, 8'h00, 1'b0); // divisor still zero
        issue(abe_pkg::OP_NOT,  8'd0,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_MUL,  FILE_LAST,        1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_STA,  FILE_LAST + 8'd1, 1'b0, 8'h00, 1'b0); // first index past file
        issue(abe_pkg::OP_LDF,  8'hFF,            1'b0, 8'h00, 1'b0); // highest index, skipped
        issue(abe_pkg::OP_INC,  8'd5,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_DEC,  8'd6,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_SHL,  8'd6,             1'b0, 8'h00, 1'b0); // shift by low bits of 0xff
        issue(abe_pkg::OP_SHR,  8'd6,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_MOD,  8'd6,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_SUB,  8'd6,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_AND,  8'd6,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_OR,   8'd5,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_XOR,  8'd6,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_GT,   8'd5,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_LT,   8'd6,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_EQ,   8'd5,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_CLRF, 8'd6,             1'b0, 8'h00, 1'b0);
        issue(abe_pkg::OP_MOD,  8'd6,             1'b0, 8'h00, 1'b1); // cleared divisor, end
        // return on the last instruction wins over end of code
        programs++;
        issue(abe_pkg::OP_RET,  8'd0,             1'b1, 8'h80, 1'b1);
        // dropped while halted, even with the last flag
        issue(abe_pkg::OP_LDI,  8'h55,            1'b0, 8'hAA, 1'b1);
        filler_items++;
        // unknown opcode on the last instruction wins over end of code
        programs++;
        issue(abe_pkg::ALL_ONES, 8'd0,            1'b1, 8'h7F, 1'b1);

        while (sent_items - filler_items < TARGET_ITEMS)
            run_program();
        s_tvalid <= 1'b0;

        for (n = 0; n < DRAIN_LIMIT && outstanding != 0; n++)
            @(posedge clk);
        // the block may still be busy on an instruction with no result
        repeat (TAIL_CYCLES) @(posedge clk);

        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        $display("covered %0d instructions in %0d programs (%0d dropped filler)",
                 sent_items, programs, filler_items);
        $display("%0d result transactions checked, %0d mismatches", checked, errors);
        if (errors == 0 && outstanding == 0)
            $display("tb_accumulator_bytecode_executor: done, clean");
        else
            $display("tb_accumulator_bytecode_executor: done, errors");
        $finish;
    end

endmodule
